// ===== design/rsds_pkg.sv =====
// ----------------------------------------------------------------------------
// rsds_pkg
// Shared types, codes and reset values for the radio sync duty scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rsds_pkg;

  // event codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TIME  = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_LISTEN = 2'd0;
  localparam logic [1:0] CFG_RETRY  = 2'd1;
  localparam logic [1:0] CFG_PERIOD = 2'd2;
  localparam logic [1:0] CFG_HOUR   = 2'd3;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;

  localparam logic [7:0]  LISTEN_RST = 8'd5;
  localparam logic [7:0]  RETRY_RST  = 8'd10;
  localparam logic [10:0] PERIOD_RST = 11'd0;
  localparam logic [4:0]  HOUR_RST   = 5'd2;

  // phase codes as reported on phase_now
  localparam logic [2:0] PCODE_INIT       = 3'd0;
  localparam logic [2:0] PCODE_FIRST_SYNC = 3'd1;
  localparam logic [2:0] PCODE_FIRST_SLP  = 3'd2;
  localparam logic [2:0] PCODE_NEXT_SYNC  = 3'd3;
  localparam logic [2:0] PCODE_NEXT_SLP   = 3'd4;

  typedef enum logic [4:0] {
    PH_INIT       = 5'b00001,
    PH_FIRST_SYNC = 5'b00010,
    PH_FIRST_SLP  = 5'b00100,
    PH_NEXT_SYNC  = 5'b01000,
    PH_NEXT_SLP   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0]  listen;
    logic [7:0]  retry;
    logic [10:0] period;
    logic [4:0]  hour;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [13:0] stop_cnt;
    logic        stop_armed;
    logic [16:0] restart_cnt;
    logic        restart_armed;
    logic        hour_armed;
    logic        rx_en;
  } sched_state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;
    logic [31:0] decoded_time;
  } item_t;

  typedef struct packed {
    logic        radio_on;
    logic        time_valid;
    logic [31:0] set_time;
    logic [2:0]  phase_now;
  } result_t;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] c;
    unique case (ph)
      PH_INIT:       c = PCODE_INIT;
      PH_FIRST_SYNC: c = PCODE_FIRST_SYNC;
      PH_FIRST_SLP:  c = PCODE_FIRST_SLP;
      PH_NEXT_SYNC:  c = PCODE_NEXT_SYNC;
      PH_NEXT_SLP:   c = PCODE_NEXT_SLP;
      default:       c = PCODE_INIT;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/rsds_cfg.sv =====
// ----------------------------------------------------------------------------
// rsds_cfg
// Configuration register file: four write-only registers with reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module rsds_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          we,
  input  wire logic [rsds_pkg::CfgIdxW-1:0]  idx,
  input  wire logic [rsds_pkg::CfgDataW-1:0] data,
  output rsds_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.listen <= rsds_pkg::LISTEN_RST;
      cfg.retry  <= rsds_pkg::RETRY_RST;
      cfg.period <= rsds_pkg::PERIOD_RST;
      cfg.hour   <= rsds_pkg::HOUR_RST;
    end else if (we) begin
      unique case (idx)
        rsds_pkg::CFG_LISTEN: cfg.listen <= data[7:0];
        rsds_pkg::CFG_RETRY:  cfg.retry  <= data[7:0];
        rsds_pkg::CFG_PERIOD: cfg.period <= data;
        rsds_pkg::CFG_HOUR:   cfg.hour   <= data[4:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/rsds_step.sv =====
// ----------------------------------------------------------------------------
// rsds_step
// Next-state and result logic for one event: countdowns, alarm, phase moves.
// ----------------------------------------------------------------------------
`default_nettype none

module rsds_step (
  input  wire rsds_pkg::cfg_t         cfg,
  input  wire rsds_pkg::sched_state_t st,
  input  wire rsds_pkg::item_t        item,
  output rsds_pkg::sched_state_t      st_next,
  output rsds_pkg::result_t           res
);

  // minutes*60 done as (m<<6)-(m<<2)
  logic [13:0] listen_w;
  logic [16:0] retry_w;
  logic [16:0] period_w;
  logic [13:0] stop_load;
  logic [16:0] retry_load;
  logic [16:0] period_load;

  assign listen_w    = 14'(cfg.listen);
  assign retry_w     = 17'(cfg.retry);
  assign period_w    = 17'(cfg.period);
  assign stop_load   = (listen_w << 6) - (listen_w << 2) + 14'd2;
  assign retry_load  = (retry_w << 6) - (retry_w << 2) - 17'd10;
  assign period_load = (period_w << 6) - (period_w << 2) - 17'd10;

  function automatic rsds_pkg::sched_state_t do_start(rsds_pkg::sched_state_t s);
    rsds_pkg::sched_state_t r;
    r = s;
    r.rx_en = 1'b1;
    if (s.phase == rsds_pkg::PH_INIT || s.phase == rsds_pkg::PH_FIRST_SLP) begin
      r.phase = rsds_pkg::PH_FIRST_SYNC;
      if (cfg.listen != 8'd0) begin
        r.stop_cnt   = stop_load;
        r.stop_armed = 1'b1;
      end
    end else if (s.phase == rsds_pkg::PH_NEXT_SLP) begin
      r.phase = rsds_pkg::PH_NEXT_SYNC;
    end
    return r;
  endfunction

  // stop action; resched set when a new restart schedule is made
  function automatic rsds_pkg::sched_state_t do_stop(rsds_pkg::sched_state_t s,
                                                     output logic resched);
    rsds_pkg::sched_state_t r;
    r = s;
    resched = 1'b0;
    r.rx_en      = 1'b0;
    r.stop_armed = 1'b0;
    if (s.phase == rsds_pkg::PH_FIRST_SYNC) begin
      r.phase = rsds_pkg::PH_FIRST_SLP;
      if (cfg.retry != 8'd0) begin
        r.restart_cnt   = retry_load;
        r.restart_armed = 1'b1;
        r.hour_armed    = 1'b0;
        resched         = 1'b1;
      end
    end else if (s.phase == rsds_pkg::PH_NEXT_SYNC) begin
      r.phase = rsds_pkg::PH_NEXT_SLP;
      if (cfg.period != 11'd0) begin
        r.restart_cnt   = period_load;
        r.restart_armed = 1'b1;
        r.hour_armed    = 1'b0;
        resched         = 1'b1;
      end else if (cfg.hour != 5'd0) begin
        r.hour_armed    = 1'b1;
        r.restart_armed = 1'b0;
        resched         = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    rsds_pkg::sched_state_t s;
    logic stop_due;
    logic restart_due;
    logic resched;
    logic valid;
    s           = st;
    stop_due    = 1'b0;
    restart_due = 1'b0;
    resched     = 1'b0;
    valid       = 1'b0;
    case (item.op)
      rsds_pkg::OP_TICK: begin
        if (s.stop_armed) begin
          s.stop_cnt = s.stop_cnt - 14'd1;
          stop_due   = (s.stop_cnt == 14'd0);
        end
        if (s.restart_armed) begin
          s.restart_cnt = s.restart_cnt - 17'd1;
          restart_due   = (s.restart_cnt == 17'd0);
        end else if (s.hour_armed) begin
          restart_due = (item.hour_now == cfg.hour) && (item.minute_now == 6'd0)
                        && (item.second_now == 6'd50);
        end
        if (stop_due) begin
          s = do_stop(s, resched);
        end
        // a schedule just replaced by the stop does not fire this tick
        if (restart_due && !resched) begin
          s.restart_armed = 1'b0;
          s.hour_armed    = 1'b0;
          s = do_start(s);
        end
      end
      rsds_pkg::OP_START: begin
        if (s.phase == rsds_pkg::PH_INIT) begin
          s = do_start(s);
        end
      end
      rsds_pkg::OP_TIME: begin
        valid   = 1'b1;
        s.phase = rsds_pkg::PH_NEXT_SYNC;
        s = do_stop(s, resched);
      end
      default: ;
    endcase
    st_next        = s;
    res.radio_on   = s.rx_en;
    res.time_valid = valid;
    res.set_time   = valid ? item.decoded_time : 32'd0;
    res.phase_now  = rsds_pkg::phase_code(s.phase);
  end

endmodule

`default_nettype wire

// ===== design/radio_sync_duty_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// radio_sync_duty_scheduler_core
// Duty-cycles a time-signal receiver across first-sync and resync phases.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one event word: op, hour_now,
//   minute_now, second_now, decoded_time. Output channel (out_valid/out_stall)
//   returns exactly one result word per event: radio_on, time_valid,
//   set_time, phase_now.
//   An accepted word enters the input register; then the event logic writes
//   the schedule state and the result register in the same cycle, raising
//   out_valid. Throughput is one word per cycle while out_stall is low.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more word, after which in_stall rises until the result
//   is taken. in_stall is never high while the input register is empty.
//   Config writes (cfg_we/cfg_index/cfg_data) take effect the next cycle and
//   are expected only while no event is in flight.
//   Reset (rst, synchronous) returns to init phase with receiver off, all
//   countdowns and the hour alarm disarmed and config at defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_sync_duty_scheduler_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rsds_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [rsds_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    op,
  input  wire logic [4:0]                    hour_now,
  input  wire logic [5:0]                    minute_now,
  input  wire logic [5:0]                    second_now,
  input  wire logic [31:0]                   decoded_time,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               radio_on,
  output logic                               time_valid,
  output logic [31:0]                        set_time,
  output logic [2:0]                         phase_now
);

  rsds_pkg::cfg_t         cfg;
  rsds_pkg::sched_state_t state;
  rsds_pkg::sched_state_t state_next;
  rsds_pkg::item_t        s1_item;
  rsds_pkg::result_t      res_next;
  logic                   s1_valid;
  logic                   advance;
  logic                   in_take;

  rsds_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .we   (cfg_we),
    .idx  (cfg_index),
    .data (cfg_data),
    .cfg  (cfg)
  );

  rsds_step u_step (
    .cfg     (cfg),
    .st      (state),
    .item    (s1_item),
    .st_next (state_next),
    .res     (res_next)
  );

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.op           <= op;
      s1_item.hour_now     <= hour_now;
      s1_item.minute_now   <= minute_now;
      s1_item.second_now   <= second_now;
      s1_item.decoded_time <= decoded_time;
    end
  end

  // schedule state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= rsds_pkg::PH_INIT;
      state.stop_cnt      <= 14'd0;
      state.stop_armed    <= 1'b0;
      state.restart_cnt   <= 17'd0;
      state.restart_armed <= 1'b0;
      state.hour_armed    <= 1'b0;
      state.rx_en         <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      radio_on   <= res_next.radio_on;
      time_valid <= res_next.time_valid;
      set_time   <= res_next.set_time;
      phase_now  <= res_next.phase_now;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall raised with empty input register");

  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && !s1_valid |-> radio_on == state.rx_en)
    else $error("radio_on disagrees with receiver state");

  a_stop_cnt_live: assert property (@(posedge clk) disable iff (rst)
    state.stop_armed |-> state.stop_cnt != 14'd0)
    else $error("stop countdown armed at zero");

  a_restart_excl: assert property (@(posedge clk) disable iff (rst)
    !(state.restart_armed && state.hour_armed))
    else $error("restart countdown and hour alarm both armed");

  a_time_to_sleep: assert property (@(posedge clk) disable iff (rst)
    out_valid && time_valid |-> phase_now == rsds_pkg::PCODE_NEXT_SLP)
    else $error("decoded time did not end in next-sleep phase");

endmodule

`default_nettype wire
